// ===== sv/rgbab_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the RGB alpha blend unit.
// No dependencies; the core, the register file and the testbench refer to it.
package rgbab_pkg;

   localparam int unsigned CHANNELS = 3;
   localparam logic [7:0] PIX_MAX = 8'd255;

   // Blend mode codes held in the blend_mode register.
   localparam logic [2:0] MODE_SRC_ALPHA    = 3'd0;
   localparam logic [2:0] MODE_OPAQUE       = 3'd1;
   localparam logic [2:0] MODE_ALPHA_OPAQUE = 3'd2;
   localparam logic [2:0] MODE_FILL         = 3'd3;
   localparam logic [2:0] MODE_COPY         = 3'd4;

   // Register indexes; register i sits at byte address 4*i.
   localparam logic [2:0] REG_BLEND_MODE = 3'd0;
   localparam logic [2:0] REG_OPAQUENESS = 3'd1;
   localparam logic [2:0] REG_FILL_RED   = 3'd2;
   localparam logic [2:0] REG_FILL_GREEN = 3'd3;
   localparam logic [2:0] REG_FILL_BLUE  = 3'd4;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Register values as seen by the datapath. Fill lanes: 0 red, 1 green, 2 blue.
   typedef struct packed {
      logic [2:0]                     blend_mode;
      logic [7:0]                     opaqueness;
      logic [CHANNELS-1:0][7:0]       fill;
   } cfg_type;

endpackage

// ===== sv/rgbab_req_if.sv =====
`timescale 1ns / 1ps
// Input channel of the blend unit: one destination and one source pixel.
// Stand-alone interface with valid/ready handshake; no dependencies.
interface rgbab_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] dst_red;
   logic [7:0] dst_green;
   logic [7:0] dst_blue;
   logic [7:0] dst_alpha;
   logic [7:0] src_red;
   logic [7:0] src_green;
   logic [7:0] src_blue;
   logic [7:0] src_alpha;

   modport source (
      output valid, dst_red, dst_green, dst_blue, dst_alpha,
             src_red, src_green, src_blue, src_alpha,
      input  ready
   );

   modport sink (
      input  valid, dst_red, dst_green, dst_blue, dst_alpha,
             src_red, src_green, src_blue, src_alpha,
      output ready
   );
endinterface

// ===== sv/rgbab_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel of the blend unit: one blended pixel per transaction.
// Stand-alone interface with valid/ready handshake; no dependencies.
interface rgbab_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;

   modport source (
      output valid, out_red, out_green, out_blue, out_alpha,
      input  ready
   );

   modport sink (
      input  valid, out_red, out_green, out_blue, out_alpha,
      output ready
   );
endinterface

// ===== sv/rgb_alpha_blend_unit_core.sv =====
`timescale 1ns / 1ps
// Top level of the RGB alpha blend unit: three-stage blend pipeline.
// Depends on rgbab_pkg, rgbab_req_if, rgbab_rsp_if and rgbab_csr.
//
// The unit takes one transaction per clock, each carrying a destination and a
// source pixel, and returns one blended pixel per transaction, in order. Every
// colour channel is computed as (x*w + y*(255-w)) >> 8, with x, y and w chosen
// by blend_mode; copy mode returns the source colour with alpha 255, and the
// undefined mode codes return the destination pixel. The pipeline has three
// register stages: operand and weight selection (including the alpha times
// opaqueness product of mode 2), the two per-channel weight products, and the
// final sum, which lands in the output register. With the result side ready
// the unit sustains one transaction per cycle. Each stage holds its data
// while the stage after it is stalled, so back-pressure loses and repeats
// nothing.
// The registers must only be written while no transaction is in flight.
module rgb_alpha_blend_unit_core (
   input  logic                                clock,
   input  logic                                reset,
   rgbab_req_if.sink                           req_bus,
   rgbab_rsp_if.source                         rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rgbab_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rgbab_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rgbab_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned NCH = rgbab_pkg::CHANNELS;

   rgbab_pkg::cfg_type cfg;

   rgbab_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Each stage moves when it is empty or the stage after it is moving.
   logic s1_ready;
   logic s2_ready;
   logic s3_ready;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;

   assign s3_ready    = !s3_valid_ff || rsp_bus.ready;
   assign s2_ready    = !s2_valid_ff || s3_ready;
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;

   assign s1_valid_in = s1_ready ? req_bus.valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff   : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff   : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Stage 1: pick the blend operands. The weight is kept as a 16-bit value
   // whose upper byte is the effective weight, so mode 2 can register the
   // raw alpha times opaqueness product and take its upper byte later.
   logic [NCH-1:0][7:0] s1_x_ff, s1_x_in;
   logic [NCH-1:0][7:0] s1_y_ff, s1_y_in;
   logic [15:0]         s1_wgt_ff, s1_wgt_in;
   logic                s1_bypass_ff, s1_bypass_in;
   logic [7:0]          s1_alpha_ff, s1_alpha_in;

   always_comb begin
      s1_x_in      = {req_bus.dst_blue, req_bus.dst_green, req_bus.dst_red};
      s1_y_in      = {req_bus.dst_blue, req_bus.dst_green, req_bus.dst_red};
      s1_wgt_in    = '0;
      s1_bypass_in = 1'b0;
      s1_alpha_in  = req_bus.dst_alpha;
      case (cfg.blend_mode)
         rgbab_pkg::MODE_SRC_ALPHA: begin
            s1_x_in   = {req_bus.src_blue, req_bus.src_green, req_bus.src_red};
            s1_wgt_in = {req_bus.src_alpha, 8'h00};
         end
         rgbab_pkg::MODE_OPAQUE: begin
            s1_x_in   = {req_bus.src_blue, req_bus.src_green, req_bus.src_red};
            s1_wgt_in = {cfg.opaqueness, 8'h00};
         end
         rgbab_pkg::MODE_ALPHA_OPAQUE: begin
            s1_x_in   = {req_bus.src_blue, req_bus.src_green, req_bus.src_red};
            s1_wgt_in = 16'(req_bus.src_alpha) * 16'(cfg.opaqueness);
         end
         rgbab_pkg::MODE_FILL: begin
            s1_y_in   = cfg.fill;
            s1_wgt_in = {req_bus.dst_alpha, 8'h00};
         end
         rgbab_pkg::MODE_COPY: begin
            s1_x_in      = {req_bus.src_blue, req_bus.src_green, req_bus.src_red};
            s1_bypass_in = 1'b1;
            s1_alpha_in  = rgbab_pkg::PIX_MAX;
         end
         default: begin
            // Undefined mode codes hand the destination pixel through.
            s1_bypass_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_x_ff      <= s1_x_in;
         s1_y_ff      <= s1_y_in;
         s1_wgt_ff    <= s1_wgt_in;
         s1_bypass_ff <= s1_bypass_in;
         s1_alpha_ff  <= s1_alpha_in;
      end
   end

   // Stage 2: one product per operand and channel.
   logic [7:0]           s2_w;
   logic [7:0]           s2_wc;
   logic [NCH-1:0][15:0] s2_px_ff, s2_px_in;
   logic [NCH-1:0][15:0] s2_py_ff, s2_py_in;
   logic [NCH-1:0][7:0]  s2_x_ff;
   logic                 s2_bypass_ff;
   logic [7:0]           s2_alpha_ff;

   assign s2_w  = s1_wgt_ff[15:8];
   assign s2_wc = rgbab_pkg::PIX_MAX - s2_w;

   // Stage 3: sum of the two products; the upper byte is the result.
   logic [NCH-1:0][7:0] s3_rgb_ff, s3_rgb_in;
   logic [7:0]          s3_alpha_ff;

   for (genvar c = 0; c < NCH; c++) begin : g_lane
      logic [16:0] sum;

      assign s2_px_in[c] = 16'(s1_x_ff[c]) * 16'(s2_w);
      assign s2_py_in[c] = 16'(s1_y_ff[c]) * 16'(s2_wc);

      assign sum          = 17'(s2_px_ff[c]) + 17'(s2_py_ff[c]);
      assign s3_rgb_in[c] = s2_bypass_ff ? s2_x_ff[c] : sum[15:8];
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_px_ff     <= s2_px_in;
         s2_py_ff     <= s2_py_in;
         s2_x_ff      <= s1_x_ff;
         s2_bypass_ff <= s1_bypass_ff;
         s2_alpha_ff  <= s1_alpha_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_rgb_ff   <= s3_rgb_in;
         s3_alpha_ff <= s2_alpha_ff;
      end
   end

   assign rsp_bus.valid     = s3_valid_ff;
   assign rsp_bus.out_red   = s3_rgb_ff[0];
   assign rsp_bus.out_green = s3_rgb_ff[1];
   assign rsp_bus.out_blue  = s3_rgb_ff[2];
   assign rsp_bus.out_alpha = s3_alpha_ff;

endmodule

// ===== sv/rgbab_csr.sv =====
`timescale 1ns / 1ps
// Configuration register file of the blend unit behind an APB-style port.
// Depends on rgbab_pkg for register indexes and the cfg_type struct.
module rgbab_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rgbab_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rgbab_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rgbab_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output rgbab_pkg::cfg_type                  cfg
);

   rgbab_pkg::cfg_type cfg_ff;
   rgbab_pkg::cfg_type cfg_in;
   logic               wr_en;
   logic [2:0]         reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[rgbab_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            rgbab_pkg::REG_BLEND_MODE: cfg_in.blend_mode = csr_pwdata[2:0];
            rgbab_pkg::REG_OPAQUENESS: cfg_in.opaqueness = csr_pwdata[7:0];
            rgbab_pkg::REG_FILL_RED:   cfg_in.fill[0]    = csr_pwdata[7:0];
            rgbab_pkg::REG_FILL_GREEN: cfg_in.fill[1]    = csr_pwdata[7:0];
            rgbab_pkg::REG_FILL_BLUE:  cfg_in.fill[2]    = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blend_mode <= rgbab_pkg::MODE_SRC_ALPHA;
         cfg_ff.opaqueness <= rgbab_pkg::PIX_MAX;
         cfg_ff.fill       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         rgbab_pkg::REG_BLEND_MODE:
            csr_prdata = rgbab_pkg::CSR_DATA_W'(cfg_ff.blend_mode);
         rgbab_pkg::REG_OPAQUENESS:
            csr_prdata = rgbab_pkg::CSR_DATA_W'(cfg_ff.opaqueness);
         rgbab_pkg::REG_FILL_RED:   csr_prdata = rgbab_pkg::CSR_DATA_W'(cfg_ff.fill[0]);
         rgbab_pkg::REG_FILL_GREEN: csr_prdata = rgbab_pkg::CSR_DATA_W'(cfg_ff.fill[1]);
         rgbab_pkg::REG_FILL_BLUE:  csr_prdata = rgbab_pkg::CSR_DATA_W'(cfg_ff.fill[2]);
         default:                   csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/rgbab_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the blend unit and the bind that attaches them.
// Depends on rgb_alpha_blend_unit_core and its channel interfaces.
module rgbab_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_red,
   input logic [7:0] out_green,
   input logic [7:0] out_blue,
   input logic [7:0] out_alpha
);

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // An accepted request reaches the output if the result side stays ready.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("result did not appear after three cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({out_red, out_green, out_blue, out_alpha}))
      else $error("result changed while stalled");

endmodule

bind rgb_alpha_blend_unit_core rgbab_checker u_rgbab_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .out_red   (rsp_bus.out_red),
   .out_green (rsp_bus.out_green),
   .out_blue  (rsp_bus.out_blue),
   .out_alpha (rsp_bus.out_alpha)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the RGB alpha blend unit: directed table, then random phases.
// Depends on rgbab_pkg, rgbab_req_if, rgbab_rsp_if and rgb_alpha_blend_unit_core.
module testbench;

   // Three register stages in the datapath.
   localparam int LATENCY        = 3;
   localparam int RANDOM_ITEMS   = 1930;
   localparam int SQUEEZE_AT     = 700;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 3000;

   // Mode codes the datapath does not define; they return the destination pixel.
   localparam logic [2:0] MODE_UNDEF_A = 3'd5;
   localparam logic [2:0] MODE_UNDEF_C = 3'd7;
   // Register indexes that decode to nothing.
   localparam logic [2:0] REG_HOLE_FIRST = 3'd5;
   localparam logic [2:0] REG_HOLE_LAST  = 3'd7;

   typedef struct packed {
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_alpha;
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
   } blend_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } blend_rsp_type;

   typedef struct {
      rgbab_pkg::cfg_type cfg;
      blend_req_type      px;
      bit                 typed;
      blend_rsp_type      want;
   } blend_case_type;

   typedef enum {STALL_NONE, STALL_HALF, STALL_RARE, STALL_PERIODIC} stall_style_type;

   logic clock = 1'b0;
   logic reset;

   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [rgbab_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [rgbab_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [rgbab_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   rgbab_req_if req_bus ();
   rgbab_rsp_if rsp_bus ();

   rgb_alpha_blend_unit_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Register values as the testbench believes the block holds them.
   rgbab_pkg::cfg_type blend_regs;
   blend_rsp_type      expected_pixels [$];
   blend_case_type     directed_cases [$];
   int unsigned        mismatch_count  = 0;
   int unsigned        pixels_accepted = 0;
   int unsigned        idle_cycles     = 0;
   int unsigned        burst_left      = 0;
   bit                 sender_gappy    = 1'b1;
   string              lane_names [4]  = '{"alpha", "blue", "green", "red"};

   // One colour channel: x weighted by w, y by 255 - w, floored by the shift.
   function automatic logic [7:0] mix_channel(input logic [7:0] x, input logic [7:0] y,
                                              input logic [7:0] w);
      int unsigned acc;
      acc = int'(x) * int'(w) + int'(y) * (int'(rgbab_pkg::PIX_MAX) - int'(w));
      return acc[15:8];
   endfunction

   function automatic blend_rsp_type blend_pixel(input rgbab_pkg::cfg_type c,
                                                 input blend_req_type p);
      blend_rsp_type r;
      int unsigned   prod;
      logic [7:0]    w;
      r = {p.dst_red, p.dst_green, p.dst_blue, p.dst_alpha};
      case (c.blend_mode)
         rgbab_pkg::MODE_SRC_ALPHA: begin
            r.red   = mix_channel(p.src_red, p.dst_red, p.src_alpha);
            r.green = mix_channel(p.src_green, p.dst_green, p.src_alpha);
            r.blue  = mix_channel(p.src_blue, p.dst_blue, p.src_alpha);
         end
         rgbab_pkg::MODE_OPAQUE: begin
            r.red   = mix_channel(p.src_red, p.dst_red, c.opaqueness);
            r.green = mix_channel(p.src_green, p.dst_green, c.opaqueness);
            r.blue  = mix_channel(p.src_blue, p.dst_blue, c.opaqueness);
         end
         rgbab_pkg::MODE_ALPHA_OPAQUE: begin
            prod    = int'(p.src_alpha) * int'(c.opaqueness);
            w       = prod[15:8];
            r.red   = mix_channel(p.src_red, p.dst_red, w);
            r.green = mix_channel(p.src_green, p.dst_green, w);
            r.blue  = mix_channel(p.src_blue, p.dst_blue, w);
         end
         rgbab_pkg::MODE_FILL: begin
            r.red   = mix_channel(p.dst_red, c.fill[0], p.dst_alpha);
            r.green = mix_channel(p.dst_green, c.fill[1], p.dst_alpha);
            r.blue  = mix_channel(p.dst_blue, c.fill[2], p.dst_alpha);
         end
         rgbab_pkg::MODE_COPY: begin
            r = {p.src_red, p.src_green, p.src_blue, rgbab_pkg::PIX_MAX};
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Random full-range values half the time, otherwise one of the two extremes.
   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 3))
         0:       return 8'd0;
         1:       return rgbab_pkg::PIX_MAX;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic add_case(input logic [2:0] mode, input logic [7:0] opq, input logic [7:0] fr,
                           input logic [7:0] fg, input logic [7:0] fb, input logic [31:0] dst,
                           input logic [31:0] src, input bit typed, input logic [31:0] want);
      blend_case_type row;
      row.cfg.blend_mode = mode;
      row.cfg.opaqueness = opq;
      row.cfg.fill[0]    = fr;
      row.cfg.fill[1]    = fg;
      row.cfg.fill[2]    = fb;
      row.px             = {dst, src};
      row.typed          = typed;
      row.want           = want;
      directed_cases.push_back(row);
   endtask

   // APB write: setup cycle, access cycle, then psel goes low before return so
   // back-to-back writes never drive psel twice in the same step. Called at a falling edge.
   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (index)
         rgbab_pkg::REG_BLEND_MODE: blend_regs.blend_mode = value[2:0];
         rgbab_pkg::REG_OPAQUENESS: blend_regs.opaqueness = value[7:0];
         rgbab_pkg::REG_FILL_RED:   blend_regs.fill[0]    = value[7:0];
         rgbab_pkg::REG_FILL_GREEN: blend_regs.fill[1]    = value[7:0];
         rgbab_pkg::REG_FILL_BLUE:  blend_regs.fill[2]    = value[7:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Upper data bits carry noise; the block must keep only the register width.
   task automatic apply_config(input rgbab_pkg::cfg_type c, input bit poke_hole);
      logic [31:0] noise;
      noise = $urandom;
      write_register(rgbab_pkg::REG_BLEND_MODE, {noise[31:3], c.blend_mode});
      noise = $urandom;
      write_register(rgbab_pkg::REG_OPAQUENESS, {noise[31:8], c.opaqueness});
      noise = $urandom;
      write_register(rgbab_pkg::REG_FILL_RED, {noise[31:8], c.fill[0]});
      noise = $urandom;
      write_register(rgbab_pkg::REG_FILL_GREEN, {noise[31:8], c.fill[1]});
      noise = $urandom;
      write_register(rgbab_pkg::REG_FILL_BLUE, {noise[31:8], c.fill[2]});
      if (poke_hole) begin
         write_register(3'($urandom_range(REG_HOLE_FIRST, REG_HOLE_LAST)), $urandom);
      end
   endtask

   // Stops offering, then waits for every outstanding pixel plus the pipeline depth.
   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   // Offers one pixel pair, starting at a falling edge, and returns at the falling
   // edge after it was accepted. Gaps may be inserted between bursts when sender_gappy is set.
   task automatic send_item(input blend_req_type px, input bit typed,
                            input blend_rsp_type want);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         if (sender_gappy && $urandom_range(0, 3) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.dst_red   <= px.dst_red;
      req_bus.dst_green <= px.dst_green;
      req_bus.dst_blue  <= px.dst_blue;
      req_bus.dst_alpha <= px.dst_alpha;
      req_bus.src_red   <= px.src_red;
      req_bus.src_green <= px.src_green;
      req_bus.src_blue  <= px.src_blue;
      req_bus.src_alpha <= px.src_alpha;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_pixels.push_back(typed ? want : blend_pixel(blend_regs, px));
      pixels_accepted++;
      @(negedge clock);
   endtask

   // Result side: stall style changes every so often; once, a long hold-off lets
   // the pipeline fill up and push back on the sender.
   initial begin
      int unsigned     cycle_no;
      stall_style_type style;
      bit              squeeze_done;
      cycle_no      = 0;
      style         = STALL_NONE;
      squeeze_done  = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!squeeze_done && pixels_accepted >= SQUEEZE_AT) begin
            squeeze_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (cycle_no % 97 == 0) style = stall_style_type'($urandom_range(0, 3));
            case (style)
               STALL_NONE: rsp_bus.ready <= 1'b1;
               STALL_HALF: rsp_bus.ready <= 1'($urandom_range(0, 1));
               STALL_RARE: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
               default:    rsp_bus.ready <= (cycle_no % 4 != 3);
            endcase
         end
         cycle_no++;
      end
   end

   // Result checker: every accepted pixel is compared lane by lane with the oldest
   // expectation.
   blend_rsp_type    rsp_got;
   blend_rsp_type    rsp_want;
   logic [3:0][7:0]  got_lanes;
   logic [3:0][7:0]  want_lanes;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_got = {rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue, rsp_bus.out_alpha};
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            $display("%0t: pixel %h arrived with nothing expected", $time, rsp_got);
         end else begin
            rsp_want   = expected_pixels.pop_front();
            got_lanes  = rsp_got;
            want_lanes = rsp_want;
            for (int k = 0; k < 4; k++) begin
               if (got_lanes[k] !== want_lanes[k]) begin
                  mismatch_count++;
                  $display("%0t: %s expected %h actual %h", $time, lane_names[k],
                           want_lanes[k], got_lanes[k]);
               end
            end
         end
      end
   end

   // Watchdog: any transaction or register access counts as progress.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_psel || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d pixels outstanding", $time,
                  expected_pixels.size());
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rgbab_pkg::cfg_type next_cfg;
      blend_req_type      px;
      int unsigned        random_sent;
      int unsigned        phase;
      int unsigned        phase_items;

      reset             = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      req_bus.valid     = 1'b0;
      req_bus.dst_red   = '0;
      req_bus.dst_green = '0;
      req_bus.dst_blue  = '0;
      req_bus.dst_alpha = '0;
      req_bus.src_red   = '0;
      req_bus.src_green = '0;
      req_bus.src_blue  = '0;
      req_bus.src_alpha = '0;

      blend_regs.blend_mode = rgbab_pkg::MODE_SRC_ALPHA;
      blend_regs.opaqueness = rgbab_pkg::PIX_MAX;
      blend_regs.fill       = '0;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed table. Rows with a typed result are the ones that follow from the
      // extremes; the rest go through the predictor. The first rows run on the
      // reset register values.
      add_case(rgbab_pkg::MODE_SRC_ALPHA, 8'hFF, 8'h00, 8'h00, 8'h00,
               32'h00000000, 32'hFFFFFFFF, 1, 32'hFEFEFE00);
      add_case(rgbab_pkg::MODE_SRC_ALPHA, 8'hFF, 8'h00, 8'h00, 8'h00,
               32'hFFFFFFFF, 32'hFFFFFF00, 1, 32'hFEFEFEFF);
      add_case(rgbab_pkg::MODE_SRC_ALPHA, 8'hFF, 8'h00, 8'h00, 8'h00,
               32'h00000000, 32'h00000000, 1, 32'h00000000);
      add_case(rgbab_pkg::MODE_SRC_ALPHA, 8'hFF, 8'h00, 8'h00, 8'h00,
               32'h12345678, 32'h9ABCDE80, 0, 32'h0);
      add_case(rgbab_pkg::MODE_SRC_ALPHA, 8'hFF, 8'h00, 8'h00, 8'h00,
               32'hFFFFFF7F, 32'hFFFFFFFF, 1, 32'hFEFEFE7F);
      // Source alpha has no say in the constant-opaqueness mode.
      add_case(rgbab_pkg::MODE_OPAQUE, 8'hFF, 8'h00, 8'h00, 8'h00,
               32'h0000005A, 32'hFFFFFF00, 1, 32'hFEFEFE5A);
      add_case(rgbab_pkg::MODE_OPAQUE, 8'h00, 8'h00, 8'h00, 8'h00,
               32'hFFFFFF00, 32'h000000FF, 1, 32'hFEFEFE00);
      add_case(rgbab_pkg::MODE_OPAQUE, 8'h80, 8'h00, 8'h00, 8'h00,
               32'h80402010, 32'h10204080, 0, 32'h0);
      add_case(rgbab_pkg::MODE_ALPHA_OPAQUE, 8'hFF, 8'h00, 8'h00, 8'h00,
               32'h000000C3, 32'hFFFFFFFF, 0, 32'h0);
      add_case(rgbab_pkg::MODE_ALPHA_OPAQUE, 8'h00, 8'h00, 8'h00, 8'h00,
               32'hFFFFFF11, 32'h000000FF, 0, 32'h0);
      add_case(rgbab_pkg::MODE_ALPHA_OPAQUE, 8'hC8, 8'h00, 8'h00, 8'h00,
               32'h3C5A7896, 32'hE1C3A55A, 0, 32'h0);
      add_case(rgbab_pkg::MODE_FILL, 8'hFF, 8'h00, 8'h00, 8'h00,
               32'hFFFFFF00, 32'h12345678, 1, 32'h00000000);
      add_case(rgbab_pkg::MODE_FILL, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               32'h12345600, 32'h9ABCDEFF, 1, 32'hFEFEFE00);
      add_case(rgbab_pkg::MODE_FILL, 8'h33, 8'h40, 8'h80, 8'hC0,
               32'hA1B2C3FF, 32'h00000000, 0, 32'h0);
      add_case(rgbab_pkg::MODE_FILL, 8'h33, 8'h40, 8'h80, 8'hC0,
               32'h55AA3380, 32'hFFFFFFFF, 0, 32'h0);
      add_case(rgbab_pkg::MODE_COPY, 8'h33, 8'h40, 8'h80, 8'hC0,
               32'h11223344, 32'h12345600, 1, 32'h123456FF);
      add_case(rgbab_pkg::MODE_COPY, 8'h33, 8'h40, 8'h80, 8'hC0,
               32'hFFFFFF00, 32'hFFFFFFFF, 1, 32'hFFFFFFFF);
      // Undefined mode codes hand back the destination pixel untouched.
      add_case(MODE_UNDEF_A, 8'h33, 8'h40, 8'h80, 8'hC0,
               32'h11223344, 32'hFFFFFFFF, 1, 32'h11223344);
      add_case(MODE_UNDEF_A + 3'd1, 8'h33, 8'h40, 8'h80, 8'hC0,
               32'hAABBCCDD, 32'h00000000, 1, 32'hAABBCCDD);
      add_case(MODE_UNDEF_C, 8'h33, 8'h40, 8'h80, 8'hC0,
               32'hFFFFFFFF, 32'h00000000, 1, 32'hFFFFFFFF);

      foreach (directed_cases[i]) begin
         if (directed_cases[i].cfg != blend_regs) begin
            drain_pipeline();
            apply_config(directed_cases[i].cfg, 1'b0);
         end
         send_item(directed_cases[i].px, directed_cases[i].typed, directed_cases[i].want);
      end

      // Random phases: the first eight walk every mode code in order, later ones
      // mostly use the defined modes. Each phase also pokes an unmapped register.
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (phase < 8) begin
            next_cfg.blend_mode = 3'(phase);
         end else if ($urandom_range(0, 7) == 0) begin
            next_cfg.blend_mode = 3'($urandom_range(MODE_UNDEF_A, MODE_UNDEF_C));
         end else begin
            next_cfg.blend_mode = 3'($urandom_range(rgbab_pkg::MODE_SRC_ALPHA,
                                                    rgbab_pkg::MODE_COPY));
         end
         next_cfg.opaqueness = pick_level();
         next_cfg.fill[0]    = pick_level();
         next_cfg.fill[1]    = pick_level();
         next_cfg.fill[2]    = pick_level();
         phase_items = (next_cfg.blend_mode > rgbab_pkg::MODE_COPY) ? $urandom_range(10, 30)
                                                                    : $urandom_range(40, 160);
         // The last phase is cut short so the run sends the planned item count.
         if (phase_items > RANDOM_ITEMS - random_sent) begin
            phase_items = RANDOM_ITEMS - random_sent;
         end
         sender_gappy = ($urandom_range(0, 3) != 0);
         drain_pipeline();
         apply_config(next_cfg, 1'b1);
         repeat (phase_items) begin
            px = {$urandom, $urandom};
            case ($urandom_range(0, 9))
               0:       px.src_alpha = 8'd0;
               1:       px.src_alpha = rgbab_pkg::PIX_MAX;
               2:       px.dst_alpha = 8'd0;
               3:       px.dst_alpha = rgbab_pkg::PIX_MAX;
               4:       px = '1;
               5:       px = '0;
               default: begin
               end
            endcase
            send_item(px, 1'b0, '0);
            random_sent++;
         end
         phase++;
      end

      drain_pipeline();
      repeat (4 * LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== rgb_alpha_blend_unit_core.f =====
sv/rgbab_pkg.sv
sv/rgbab_req_if.sv
sv/rgbab_rsp_if.sv
sv/rgbab_csr.sv
sv/rgb_alpha_blend_unit_core.sv
sv/rgbab_checker.sv
dv/testbench.sv
